@@ rtl/core/adsr_pkg.sv @@
// Package for the ADSR envelope gain block: gain constants, phase codes,
// register indexes and the control struct passed along the pipeline.
// No dependencies.
`default_nettype none

package adsr_pkg;

    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

    // Quotient bits produced by the divider; every ramp quotient is at most 1.0.
    localparam int QUOT_W = 16;

    localparam logic [2:0] MODE_ZERO = 3'd0;
    localparam logic [2:0] MODE_ATT  = 3'd1;
    localparam logic [2:0] MODE_DEC  = 3'd2;
    localparam logic [2:0] MODE_SUS  = 3'd3;
    localparam logic [2:0] MODE_REL  = 3'd4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DROP    = 3'd6;

    typedef struct packed {
        logic [2:0]          mode;
        logic                neg;
        logic signed [GAIN_W:0] base;
    } gain_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/adsr_phase.sv @@
// Six-stage phase detector: works out which envelope phase a tick falls in
// and the ramp operands for the divider. Depends on adsr_pkg.
`default_nettype none

module adsr_phase #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [TIME_BITS-1:0]          start_tick,
    input  wire logic [TIME_BITS-1:0]          attack_ticks,
    input  wire logic [TIME_BITS-1:0]          decay_ticks,
    input  wire logic [TIME_BITS-1:0]          release_ticks,
    input  wire logic signed [TIME_BITS+2:0]   sustain_ticks,
    input  wire logic [adsr_pkg::GAIN_W-1:0]   peak_gain,
    input  wire logic [adsr_pkg::GAIN_W-1:0]   decay_drop,
    input  wire logic signed [adsr_pkg::GAIN_W:0] level,
    input  wire logic [adsr_pkg::GAIN_W-1:0]   level_mag,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [TIME_BITS-1:0]          in_tick,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [TIME_BITS-1:0]               out_x,
    output logic [adsr_pkg::GAIN_W-1:0]        out_y,
    output logic [TIME_BITS-1:0]               out_div,
    output adsr_pkg::gain_ctl_t                out_ctl,
    output logic signed [SAMPLE_BITS-1:0]      out_sample
);
    import adsr_pkg::*;

    localparam int NST = 6;
    localparam int EW  = TIME_BITS + 3;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    logic [TIME_BITS-1:0]          t1_reg;
    logic signed [SAMPLE_BITS-1:0] s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    logic                          zero2_reg, zero3_reg, zero4_reg, zero5_reg;
    logic [TIME_BITS-1:0]          dt2_reg, dt3_reg, dt4_reg, dt5_reg;
    logic                          att3_reg, att4_reg, att5_reg;
    logic [TIME_BITS-1:0]          e1_3_reg, e1_4_reg, e1_5_reg;
    logic                          dec4_reg, dec5_reg;
    logic [TIME_BITS-1:0]          e2_4_reg;
    logic                          sus5_reg;
    logic signed [EW-1:0]          e3_5_reg;

    logic signed [EW-1:0] e2_ext;
    logic                 rel_hit;
    logic [TIME_BITS-1:0] rel_left;
    logic [TIME_BITS-1:0] x_next, div_next;
    logic [GAIN_W-1:0]    y_next;
    gain_ctl_t            ctl_next;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign e2_ext   = $signed({3'b000, e2_4_reg});
    assign rel_hit  = e3_5_reg < $signed({3'b000, release_ticks});
    assign rel_left = release_ticks - e3_5_reg[TIME_BITS-1:0];

    always_comb begin
        x_next        = '0;
        y_next        = '0;
        div_next      = attack_ticks;
        ctl_next.mode = MODE_ZERO;
        ctl_next.neg  = 1'b0;
        ctl_next.base = '0;
        if (zero5_reg) begin
            ctl_next.mode = MODE_ZERO;
        end else if (att5_reg) begin
            ctl_next.mode = MODE_ATT;
            x_next        = dt5_reg;
            y_next        = peak_gain;
            div_next      = attack_ticks;
        end else if (dec5_reg) begin
            ctl_next.mode = MODE_DEC;
            ctl_next.base = $signed({1'b0, peak_gain});
            x_next        = e1_5_reg;
            y_next        = decay_drop;
            div_next      = decay_ticks;
        end else if (sus5_reg) begin
            ctl_next.mode = MODE_SUS;
            ctl_next.base = level;
        end else if (rel_hit) begin
            ctl_next.mode = MODE_REL;
            ctl_next.neg  = level[GAIN_W];
            x_next        = rel_left;
            y_next        = level_mag;
            div_next      = release_ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t1_reg <= in_tick;
            s1_reg <= in_sample;
        end
        if (en[1]) begin
            zero2_reg <= t1_reg < start_tick;
            dt2_reg   <= t1_reg - start_tick;
            s2_reg    <= s1_reg;
        end
        if (en[2]) begin
            zero3_reg <= zero2_reg;
            att3_reg  <= !zero2_reg && (dt2_reg < attack_ticks);
            dt3_reg   <= dt2_reg;
            e1_3_reg  <= dt2_reg - attack_ticks;
            s3_reg    <= s2_reg;
        end
        if (en[3]) begin
            zero4_reg <= zero3_reg;
            att4_reg  <= att3_reg;
            dec4_reg  <= !zero3_reg && !att3_reg && (e1_3_reg < decay_ticks);
            dt4_reg   <= dt3_reg;
            e1_4_reg  <= e1_3_reg;
            e2_4_reg  <= e1_3_reg - decay_ticks;
            s4_reg    <= s3_reg;
        end
        if (en[4]) begin
            zero5_reg <= zero4_reg;
            att5_reg  <= att4_reg;
            dec5_reg  <= dec4_reg;
            sus5_reg  <= !zero4_reg && !att4_reg && !dec4_reg && (e2_ext < sustain_ticks);
            e3_5_reg  <= e2_ext - sustain_ticks;
            dt5_reg   <= dt4_reg;
            e1_5_reg  <= e1_4_reg;
            s5_reg    <= s4_reg;
        end
        if (en[5]) begin
            out_x   <= x_next;
            out_y   <= y_next;
            out_div <= div_next;
            out_ctl <= ctl_next;
            s6_reg  <= s5_reg;
        end
    end

    assign out_sample = s6_reg;

endmodule

`default_nettype wire

@@ rtl/core/adsr_div.sv @@
// Pipelined ramp unit: one multiply stage, then a restoring divider that
// settles one quotient bit per stage. Depends on adsr_pkg.
`default_nettype none

module adsr_div #(
    parameter int TIME_BITS = 32,
    parameter int SIDE_W    = 37
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [TIME_BITS-1:0]        in_x,
    input  wire logic [adsr_pkg::GAIN_W-1:0] in_y,
    input  wire logic [TIME_BITS-1:0]        in_div,
    input  wire logic [SIDE_W-1:0]           in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [adsr_pkg::QUOT_W-1:0]      out_quot,
    output logic [SIDE_W-1:0]                out_side
);
    import adsr_pkg::*;

    localparam int NW  = TIME_BITS + GAIN_W;
    localparam int NST = QUOT_W + 1;

    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    en;
    logic [NW-1:0]     rem_reg  [NST];
    logic [TIME_BITS-1:0] div_reg [NST];
    logic [QUOT_W-1:0] quot_reg [NST];
    logic [SIDE_W-1:0] side_reg [NST];

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];
    assign out_quot  = quot_reg[NST-1];
    assign out_side  = side_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= NW'(in_x) * NW'(in_y);
            div_reg[0]  <= in_div;
            quot_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // The product is below the divisor times 2^16, so sixteen trial
    // subtractions of the shifted divisor give the whole quotient.
    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        localparam int SH = QUOT_W - 1 - k;
        logic [NW-1:0] trial;
        logic          fits;

        assign trial = {{GAIN_W{1'b0}}, div_reg[k]} << SH;
        assign fits  = rem_reg[k] >= trial;

        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                rem_reg[k+1]  <= fits ? rem_reg[k] - trial : rem_reg[k];
                div_reg[k+1]  <= div_reg[k];
                quot_reg[k+1] <= quot_reg[k] | (QUOT_W'(fits) << SH);
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/adsr_scale.sv @@
// Output scaler: forms the gain from the ramp quotient, multiplies the
// sample by it, rounds half up and saturates. Depends on adsr_pkg.
`default_nettype none

module adsr_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [adsr_pkg::QUOT_W-1:0]   in_quot,
    input  wire adsr_pkg::gain_ctl_t           in_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      out_sample
);
    import adsr_pkg::*;

    localparam int NST = 3;
    localparam int GW  = GAIN_W + 1;
    localparam int PW  = SAMPLE_BITS + GW;
    localparam int RW  = PW + 1 - (GAIN_W - 1);
    localparam logic signed [RW-1:0] SMAX = RW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] SMIN = -RW'(2 ** (SAMPLE_BITS - 1));
    localparam logic signed [PW:0]   HALF = (PW + 1)'(2 ** (GAIN_W - 2));

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    logic signed [GW-1:0]          gain_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic signed [GW-1:0] quot_s;
    logic signed [GW-1:0] gain_next;
    logic signed [PW:0]   biased;
    logic signed [RW-1:0] rounded;
    logic signed [SAMPLE_BITS-1:0] out_next;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready   = en[0];
    assign out_valid  = vld_reg[NST-1];
    assign out_sample = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign quot_s = $signed({1'b0, in_quot});

    always_comb begin
        unique case (in_ctl.mode)
            MODE_ATT: gain_next = quot_s;
            MODE_DEC: gain_next = in_ctl.base - quot_s;
            MODE_SUS: gain_next = in_ctl.base;
            MODE_REL: gain_next = in_ctl.neg ? -quot_s : quot_s;
            default:  gain_next = '0;
        endcase
    end

    // Adding one half and shifting arithmetically rounds to nearest, ties towards plus infinity.
    assign biased  = $signed({prod_reg[PW-1], prod_reg}) + HALF;
    assign rounded = RW'(biased >>> (GAIN_W - 1));

    always_comb begin
        if (rounded > SMAX) begin
            out_next = SMAX[SAMPLE_BITS-1:0];
        end else if (rounded < SMIN) begin
            out_next = SMIN[SAMPLE_BITS-1:0];
        end else begin
            out_next = rounded[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            gain_reg <= gain_next;
            samp_reg <= in_sample;
        end
        if (en[1]) begin
            prod_reg <= PW'(gain_reg) * PW'(samp_reg);
        end
        if (en[2]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/adsr_envelope_gain.sv @@
// ADSR envelope gain, top level: configuration registers and the phase,
// ramp-division and scaling pipelines. Depends on adsr_pkg and all adsr_ modules.
// Throughput: one request per cycle while m_ready does not stall the output;
// the divider's sixteen quotient stages set most of the depth.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// default envelope: start 0, ramps of 480 ticks, total 48000, peak 1.0, drop 0.25.
`default_nettype none

module adsr_envelope_gain #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [TIME_BITS-1:0]              cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [TIME_BITS-1:0]              s_time_tick,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_sample_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_sample_out
);
    import adsr_pkg::*;

    localparam int EW     = TIME_BITS + 3;
    localparam int SIDE_W = $bits(gain_ctl_t) + SAMPLE_BITS;

    logic [TIME_BITS-1:0] start_reg, attack_reg, decay_reg, release_reg, total_reg;
    logic [GAIN_W-1:0]    peak_reg, drop_reg;
    logic signed [EW-1:0] sustain_reg;
    logic signed [GAIN_W:0] level_reg;
    logic [GAIN_W-1:0]    level_mag_reg;

    logic [GAIN_W-1:0]    gain_wr;
    logic [GAIN_W-1:0]    gain_clamped;
    logic signed [GAIN_W:0] level_next;

    logic                 ph_valid, ph_ready;
    logic [TIME_BITS-1:0] ph_x, ph_div;
    logic [GAIN_W-1:0]    ph_y;
    gain_ctl_t            ph_ctl;
    logic signed [SAMPLE_BITS-1:0] ph_sample;

    logic                 dv_valid, dv_ready;
    logic [QUOT_W-1:0]    dv_quot;
    logic [SIDE_W-1:0]    dv_side;
    gain_ctl_t            dv_ctl;
    logic signed [SAMPLE_BITS-1:0] dv_sample;

    assign gain_wr      = cfg_wdata[GAIN_W-1:0];
    assign gain_clamped = (gain_wr > GAIN_ONE) ? GAIN_ONE : gain_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            attack_reg  <= TIME_BITS'(480);
            decay_reg   <= TIME_BITS'(480);
            release_reg <= TIME_BITS'(480);
            total_reg   <= TIME_BITS'(48000);
            peak_reg    <= GAIN_ONE;
            drop_reg    <= GAIN_W'(8192);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START:   start_reg   <= cfg_wdata;
                REG_ATTACK:  attack_reg  <= cfg_wdata;
                REG_DECAY:   decay_reg   <= cfg_wdata;
                REG_RELEASE: release_reg <= cfg_wdata;
                REG_TOTAL:   total_reg   <= cfg_wdata;
                REG_PEAK:    peak_reg    <= gain_clamped;
                REG_DROP:    drop_reg    <= gain_clamped;
                default: ;
            endcase
        end
    end

    // Derived values follow the registers in the next cycle; a request passes
    // through the input stage before it reads them.
    assign level_next = $signed({1'b0, peak_reg}) - $signed({1'b0, drop_reg});

    always_ff @(posedge aclk) begin
        sustain_reg   <= $signed({3'b000, total_reg}) - $signed({3'b000, attack_reg})
                         - $signed({3'b000, decay_reg}) - $signed({3'b000, release_reg});
        level_reg     <= level_next;
        level_mag_reg <= level_next[GAIN_W] ? GAIN_W'(-level_next) : GAIN_W'(level_next);
    end

    adsr_phase #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_phase (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_tick    (start_reg),
        .attack_ticks  (attack_reg),
        .decay_ticks   (decay_reg),
        .release_ticks (release_reg),
        .sustain_ticks (sustain_reg),
        .peak_gain     (peak_reg),
        .decay_drop    (drop_reg),
        .level         (level_reg),
        .level_mag     (level_mag_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_tick       (s_time_tick),
        .in_sample     (s_sample_in),
        .out_valid     (ph_valid),
        .out_ready     (ph_ready),
        .out_x         (ph_x),
        .out_y         (ph_y),
        .out_div       (ph_div),
        .out_ctl       (ph_ctl),
        .out_sample    (ph_sample)
    );

    adsr_div #(
        .TIME_BITS (TIME_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_x      (ph_x),
        .in_y      (ph_y),
        .in_div    (ph_div),
        .in_side   ({ph_ctl, ph_sample}),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    assign dv_ctl    = dv_side[SIDE_W-1:SAMPLE_BITS];
    assign dv_sample = $signed(dv_side[SAMPLE_BITS-1:0]);

    adsr_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dv_valid),
        .in_ready   (dv_ready),
        .in_quot    (dv_quot),
        .in_ctl     (dv_ctl),
        .in_sample  (dv_sample),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sample (m_sample_out)
    );

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while the output stage is empty");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (peak_reg <= GAIN_ONE) && (drop_reg <= GAIN_ONE))
        else $error("gain register above unity");

    a_ramp_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid && (dv_ctl.mode == MODE_ATT || dv_ctl.mode == MODE_DEC)
        |-> dv_quot <= GAIN_ONE)
        else $error("ramp quotient above unity");

endmodule

`default_nettype wire
